FILE: rtl/core/hb64_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hb64_pkg
// Shared types, constants and the base64 alphabet for the hex-to-base64
// encoder.
// ----------------------------------------------------------------------------
package hb64_pkg;

  localparam int unsigned GroupBits = 24;
  localparam int unsigned UnitBits  = 6;
  localparam int unsigned CharW     = 8;
  localparam int unsigned CountW    = 5;
  localparam int unsigned UnitsW    = 3;

  localparam logic [CharW-1:0]  PadChar   = 8'd61;
  localparam logic [CharW-1:0]  ErrChar   = 8'd0;
  localparam logic [CountW-1:0] FullCount = CountW'(GroupBits);
  localparam logic [CountW-1:0] NibbleBits = 5'd4;

  // one group of up to four output beats, bits left-aligned
  typedef struct packed {
    logic [GroupBits-1:0] bits;
    logic [UnitsW-1:0]    units;
    logic                 end_f;
    logic                 err;
  } grp_t;

  // base64 alphabet
  function automatic logic [CharW-1:0] b64_char(input logic [UnitBits-1:0] v);
    logic [CharW-1:0] c;
    begin
      if (v < 6'd26) begin
        c = 8'd65 + {2'b00, v};
      end else if (v < 6'd52) begin
        c = 8'd71 + {2'b00, v};
      end else if (v < 6'd62) begin
        c = {2'b00, v} - 8'd4;
      end else if (v == 6'd62) begin
        c = 8'd43;
      end else begin
        c = 8'd47;
      end
      return c;
    end
  endfunction

  // number of 6-bit units needed for a bit count (always a multiple of four)
  function automatic logic [UnitsW-1:0] units_of(input logic [CountW-1:0] n);
    logic [UnitsW-1:0] u;
    begin
      unique case (n)
        5'd4:    u = 3'd1;
        5'd8:    u = 3'd2;
        5'd12:   u = 3'd2;
        5'd16:   u = 3'd3;
        5'd20:   u = 3'd4;
        5'd24:   u = 3'd4;
        default: u = 3'd4;
      endcase
      return u;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hb64_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hb64_in_if
// Input channel: one hex string character per beat.
// ----------------------------------------------------------------------------
interface hb64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hex_char;
  logic       final_char;

  modport source (output valid, output hex_char, output final_char, input ready);
  modport sink   (input valid, input hex_char, input final_char, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hb64_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hb64_out_if
// Output channel: one base64 character, pad or error marker per beat.
// ----------------------------------------------------------------------------
interface hb64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;
  logic       string_end;
  logic       odd_length_error;

  modport source (output valid, output out_char, output run_last, output string_end,
                  output odd_length_error, input ready);
  modport sink   (input valid, input out_char, input run_last, input string_end,
                  input odd_length_error, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hb64_pack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hb64_pack
// Collects nibbles into a 24-bit group, tracks length parity and hands
// finished groups to a one-entry holding slot.
// ----------------------------------------------------------------------------
module hb64_pack import hb64_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic [7:0] hex_char_i,
  input  wire logic       final_char_i,
  output      logic       pend_valid_o,
  output      grp_t       pend_o,
  input  wire logic       pend_take_i
);

  logic [GroupBits-1:0] bits_q, bits_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic                 par_q, par_d;
  logic                 pend_v_q, pend_v_d;
  grp_t                 pend_q, pend_d;

  logic                 fire;
  logic                 is_hex;
  logic [3:0]           nib;
  logic [GroupBits-1:0] bits_n;
  logic [CountW-1:0]    cnt_n;
  logic                 par_n;
  logic                 emit;
  grp_t                 grp;

  assign in_ready_o = !pend_v_q || pend_take_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    is_hex = 1'b0;
    nib    = 4'd0;
    if (hex_char_i >= 8'd48 && hex_char_i <= 8'd57) begin
      is_hex = 1'b1;
      nib    = 4'(hex_char_i - 8'd48);
    end else if (hex_char_i >= 8'd97 && hex_char_i <= 8'd102) begin
      is_hex = 1'b1;
      nib    = 4'(hex_char_i - 8'd87);
    end

    par_n  = ~par_q;
    bits_n = is_hex ? {bits_q[GroupBits-5:0], nib} : bits_q;
    cnt_n  = is_hex ? cnt_q + NibbleBits : cnt_q;

    grp.bits  = GroupBits'(bits_n << (FullCount - cnt_n));
    grp.units = units_of(cnt_n);
    grp.end_f = final_char_i;
    grp.err   = final_char_i && par_n;

    if (final_char_i) begin
      emit = par_n || (cnt_n != '0);
    end else begin
      emit = (cnt_n == FullCount);
    end

    bits_d   = bits_q;
    cnt_d    = cnt_q;
    par_d    = par_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q && !pend_take_i;
    if (fire) begin
      if (final_char_i || emit) begin
        bits_d = '0;
        cnt_d  = '0;
        par_d  = final_char_i ? 1'b0 : par_n;
      end else begin
        bits_d = bits_n;
        cnt_d  = cnt_n;
        par_d  = par_n;
      end
      if (emit) begin
        pend_d   = grp;
        pend_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q   <= '0;
      cnt_q    <= '0;
      par_q    <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      bits_q   <= bits_d;
      cnt_q    <= cnt_d;
      par_q    <= par_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  assign pend_valid_o = pend_v_q;
  assign pend_o       = pend_q;

endmodule
`default_nettype wire

FILE: rtl/core/hb64_serial.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hb64_serial
// Holds one group and sends it out as four character beats, or one beat
// for an error marker.
// ----------------------------------------------------------------------------
module hb64_serial import hb64_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             pend_valid_i,
  input  wire grp_t             pend_i,
  output      logic             pend_take_o,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [CharW-1:0] out_char_o,
  output      logic             run_last_o,
  output      logic             string_end_o,
  output      logic             odd_length_error_o
);

  logic       ser_v_q, ser_v_d;
  grp_t       grp_q, grp_d;
  logic [1:0] idx_q, idx_d;

  logic                fire;
  logic                last;
  logic [UnitBits-1:0] unit;

  always_comb begin
    case (idx_q)
      2'd0:    unit = grp_q.bits[23:18];
      2'd1:    unit = grp_q.bits[17:12];
      2'd2:    unit = grp_q.bits[11:6];
      default: unit = grp_q.bits[5:0];
    endcase
  end

  always_comb begin
    last = grp_q.err || (idx_q == 2'd3);
    if (grp_q.err) begin
      out_char_o = ErrChar;
    end else if ({1'b0, idx_q} < grp_q.units) begin
      out_char_o = b64_char(unit);
    end else begin
      out_char_o = PadChar;
    end
    run_last_o         = last;
    string_end_o       = last && grp_q.end_f;
    odd_length_error_o = grp_q.err;
  end

  assign out_valid_o = ser_v_q;
  assign fire        = ser_v_q && out_ready_i;
  assign pend_take_o = !ser_v_q || (fire && last);

  always_comb begin
    ser_v_d = ser_v_q;
    grp_d   = grp_q;
    idx_d   = idx_q;
    if (pend_take_o) begin
      ser_v_d = pend_valid_i;
      grp_d   = pend_i;
      idx_d   = 2'd0;
    end else if (fire) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      ser_v_q <= ser_v_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

endmodule
`default_nettype wire

FILE: rtl/core/hex_to_base64_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hex_to_base64_encoder_top
// Streaming hex-string to base64 encoder, one character in per beat.
// ----------------------------------------------------------------------------
// One ASCII character is taken per input beat and one input beat can be
// accepted every clock cycle unless stalled. Lower-case hex digits add four
// bits each to a 24-bit group; any other character only counts towards the
// length. A full group, or the remainder on the final character, leaves as
// four output beats (base64 characters then '=' pads), one per cycle while
// the output is ready. An odd string length gives a single error beat
// (out_char 0, all flags set) on the final character instead, and the state
// is cleared; beats already sent stand. Finished groups go to a one-group
// holding slot with a four-beat serialiser behind it, so input stalls only
// when both hold a group, as when short final strings come faster than four
// output beats each. Input ready depends combinationally on output ready.
// ----------------------------------------------------------------------------
module hex_to_base64_encoder_top import hb64_pkg::*; (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  hb64_in_if.sink   in_ch,
  hb64_out_if.source out_ch
);

  // group handed from the packer to the serialiser
  logic pend_valid;
  grp_t pend;
  logic pend_take;

  // nibble packing, parity tracking and the holding slot
  hb64_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_ch.valid),
    .in_ready_o   (in_ch.ready),
    .hex_char_i   (in_ch.hex_char),
    .final_char_i (in_ch.final_char),
    .pend_valid_o (pend_valid),
    .pend_o       (pend),
    .pend_take_i  (pend_take)
  );

  // one beat per cycle towards the output channel while it is ready
  hb64_serial u_serial (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pend_valid_i       (pend_valid),
    .pend_i             (pend),
    .pend_take_o        (pend_take),
    .out_valid_o        (out_ch.valid),
    .out_ready_i        (out_ch.ready),
    .out_char_o         (out_ch.out_char),
    .run_last_o         (out_ch.run_last),
    .string_end_o       (out_ch.string_end),
    .odd_length_error_o (out_ch.odd_length_error)
  );

endmodule
`default_nettype wire

FILE: rtl/core/hb64_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hb64_check
// Port-level checks on the encoder output channel.
// ----------------------------------------------------------------------------
module hb64_check (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_char_i,
  input wire logic       run_last_i,
  input wire logic       string_end_i,
  input wire logic       odd_length_error_i
);

  // a stalled beat stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // a stalled beat keeps its payload
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_char_i) && $stable(run_last_i)
      && $stable(string_end_i) && $stable(odd_length_error_i))
    else $error("output payload changed while stalled");

  // error beat carries no character and closes the string
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && odd_length_error_i |-> out_char_i == 8'd0 && run_last_i && string_end_i)
    else $error("malformed error beat");

  // end of string is always the last beat of its item
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && string_end_i |-> run_last_i)
    else $error("string end without run last");

endmodule

bind hex_to_base64_encoder_top hb64_check u_hb64_check (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_ch.valid),
  .out_ready_i        (out_ch.ready),
  .out_char_i         (out_ch.out_char),
  .run_last_i         (out_ch.run_last),
  .string_end_i       (out_ch.string_end),
  .odd_length_error_i (out_ch.odd_length_error)
);
`default_nettype wire
